### hdl/llqm_pkg.sv
// Shared types and codes of the linked list queue manager.
`default_nettype none

package llqm_pkg;

    // Command codes carried on the input channel.
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam int NODE_W = 8;
    localparam int CMD_W  = 2;

endpackage

`default_nettype wire

### hdl/linked_list_queue_manager_core.sv
// Queue of node indices kept as a doubly linked list in two link memories.
//
// Usage: each request on the s_axis channel carries a command in s_axis_tuser and a
// node index in s_axis_tdata. Push appends the node at the tail, pop takes the head
// off, remove unlinks the node wherever it sits, and clear empties the queue.
// Every request gives exactly one response on the m_axis channel with the popped
// node, the queue count after the command and a status flag.
// Operation: a request is taken in the idle state; in that cycle the
// link memories are read (pop and remove) or the new node's links are written
// (push). In the exec state, once the output register is free or being read,
// the neighbour links, head, tail and count are updated and the response is
// loaded into the output register; the link memory reads are registered.
// A new request is taken while a response still waits in the output register.
// When the receiver stalls with a response pending, the next request waits in
// the exec state until the output register frees up; nothing is lost.
// Reset empties the queue (head and tail none, count zero); the link memories are
// not cleared, since every entry is written before it is followed.
`default_nettype none

module linked_list_queue_manager_core #(
    parameter int NODES = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // node [7:0]
    input  wire logic [7:0]                         s_axis_tdata,
    // cmd [1:0]
    input  wire logic [1:0]                         s_axis_tuser,

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // popped_node [7:0], queue_count [8+PW-1:8], zero fill above
    output logic [((8 + $clog2(NODES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // pop_valid [0], status [1]
    output logic [1:0]                              m_axis_tuser
);

    localparam int PW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam int DW = ((8 + PW + 7) / 8) * 8;
    localparam logic [PW-1:0] NONE = PW'(NODES);

    // Link memories.
    logic [PW-1:0] next_link [NODES];
    logic [PW-1:0] prev_link [NODES];

    logic          nl_we;
    logic [AW-1:0] nl_waddr;
    logic [PW-1:0] nl_wdata;
    logic          pl_we;
    logic [AW-1:0] pl_waddr;
    logic [PW-1:0] pl_wdata;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] nx_rd_reg;
    logic [PW-1:0] pv_rd_reg;

    llqm_pkg::state_t state_reg, state_next;
    llqm_pkg::cmd_t   cmd_reg;
    logic [7:0]       node_reg;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [PW-1:0]    count_reg, count_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       popped_reg, popped_next;
    logic             pvalid_reg, pvalid_next;
    logic [PW-1:0]    out_count_reg, out_count_next;
    logic             status_reg, status_next;

    logic             in_fire;
    logic             done;
    logic             in_node_ok;
    logic             node_ok;
    logic [PW-1:0]    node_ptr;
    llqm_pkg::cmd_t   in_cmd;

    assign in_cmd        = llqm_pkg::cmd_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == llqm_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign done          = (state_reg == llqm_pkg::ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign in_node_ok    = (32'(s_axis_tdata) < NODES);
    assign node_ok       = (32'(node_reg) < NODES);
    assign node_ptr      = PW'(node_reg);
    assign rd_addr       = (in_cmd == llqm_pkg::CMD_POP) ? head_reg[AW-1:0]
                                                         : AW'(s_axis_tdata);

    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            next_link[nl_waddr] <= nl_wdata;
        end
        if (in_fire)
        begin
            nx_rd_reg <= next_link[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            prev_link[pl_waddr] <= pl_wdata;
        end
        if (in_fire)
        begin
            pv_rd_reg <= prev_link[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        popped_next    = popped_reg;
        pvalid_next    = pvalid_reg;
        out_count_next = out_count_reg;
        status_next    = status_reg;
        nl_we          = 1'b0;
        nl_waddr       = '0;
        nl_wdata       = '0;
        pl_we          = 1'b0;
        pl_waddr       = '0;
        pl_wdata       = '0;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            llqm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = llqm_pkg::ST_EXEC;
                    // The new node's own links need no reads, so they go in at once.
                    if (in_cmd == llqm_pkg::CMD_PUSH && in_node_ok && count_reg < NONE)
                    begin
                        nl_we    = 1'b1;
                        nl_waddr = AW'(s_axis_tdata);
                        nl_wdata = NONE;
                        pl_we    = 1'b1;
                        pl_waddr = AW'(s_axis_tdata);
                        pl_wdata = (count_reg == '0) ? NONE : tail_reg;
                    end
                end
            end
            llqm_pkg::ST_EXEC:
            begin
                if (done)
                begin
                    state_next     = llqm_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    popped_next    = '0;
                    pvalid_next    = 1'b0;
                    status_next    = 1'b0;
                    case (cmd_reg)
                        llqm_pkg::CMD_PUSH:
                        begin
                            if (node_ok && count_reg < NONE)
                            begin
                                if (count_reg == '0)
                                begin
                                    head_next = node_ptr;
                                end
                                else if (tail_reg < NONE)
                                begin
                                    nl_we    = 1'b1;
                                    nl_waddr = tail_reg[AW-1:0];
                                    nl_wdata = node_ptr;
                                end
                                tail_next  = node_ptr;
                                count_next = count_reg + PW'(1);
                            end
                        end
                        llqm_pkg::CMD_POP:
                        begin
                            if (count_reg == '0 || head_reg >= NONE)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                popped_next = 8'(head_reg);
                                pvalid_next = 1'b1;
                                if (count_reg == PW'(1))
                                begin
                                    head_next = NONE;
                                    tail_next = NONE;
                                end
                                else
                                begin
                                    head_next = nx_rd_reg;
                                    if (nx_rd_reg < NONE)
                                    begin
                                        pl_we    = 1'b1;
                                        pl_waddr = nx_rd_reg[AW-1:0];
                                        pl_wdata = NONE;
                                    end
                                end
                                count_next = count_reg - PW'(1);
                            end
                        end
                        llqm_pkg::CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = 1'b1;
                            end
                            else if (node_ok)
                            begin
                                if (node_ptr == head_reg)
                                begin
                                    head_next = nx_rd_reg;
                                end
                                else if (pv_rd_reg < NONE)
                                begin
                                    nl_we    = 1'b1;
                                    nl_waddr = pv_rd_reg[AW-1:0];
                                    nl_wdata = nx_rd_reg;
                                end
                                if (node_ptr == tail_reg)
                                begin
                                    tail_next = pv_rd_reg;
                                end
                                else if (nx_rd_reg < NONE)
                                begin
                                    pl_we    = 1'b1;
                                    pl_waddr = nx_rd_reg[AW-1:0];
                                    pl_wdata = pv_rd_reg;
                                end
                                count_next = count_reg - PW'(1);
                            end
                        end
                        default:
                        begin
                            head_next  = NONE;
                            tail_next  = NONE;
                            count_next = '0;
                        end
                    endcase
                    out_count_next = count_next;
                end
            end
            default:
            begin
                state_next = llqm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llqm_pkg::ST_IDLE;
            head_reg      <= NONE;
            tail_reg      <= NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= in_cmd;
            node_reg <= s_axis_tdata;
        end
        popped_reg    <= popped_next;
        pvalid_reg    <= pvalid_next;
        out_count_reg <= out_count_next;
        status_reg    <= status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DW'({out_count_reg, popped_reg});
    assign m_axis_tuser  = {status_reg, pvalid_reg};

endmodule

`default_nettype wire

### sim/linked_list_queue_manager_core_tb.sv
// Self-checking testbench for the linked list queue manager, directed and random traffic.
module linked_list_queue_manager_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES          = 256;
    localparam int CNT_W          = $clog2(NODES + 1);
    localparam int RESP_W         = ((8 + CNT_W + 7) / 8) * 8;
    localparam logic [8:0] NO_NODE = 9'd256;
    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 40;

    // Node selection modes for the random stimulus.
    localparam int PICK_FREE    = 0;
    localparam int PICK_MEMBER  = 1;
    localparam int PICK_WRITTEN = 2;

    typedef struct packed {
        logic [7:0]       popped_node;
        logic             pop_valid;
        logic [CNT_W-1:0] queue_count;
        logic             status;
    } queue_resp_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [RESP_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    // Shadow of the queue state, updated as each request is accepted.
    logic [8:0]  next_mem [NODES];
    logic [8:0]  prev_mem [NODES];
    logic [8:0]  head_idx;
    logic [8:0]  tail_idx;
    logic [8:0]  elem_count;
    bit          in_queue [NODES];
    bit          links_written [NODES];
    queue_resp_t expected_resp_q [$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req_id = 0;
    int stall_ack_id = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    linked_list_queue_manager_core #(
        .NODES(NODES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    task automatic apply_queue_command(input llqm_pkg::cmd_t cmd, input logic [7:0] node);
        queue_resp_t resp;
        logic [8:0]  nx;
        logic [8:0]  pv;
        logic [7:0]  top;
        resp = '0;
        case (cmd)
            llqm_pkg::CMD_PUSH:
            begin
                if (elem_count < NODES)
                begin
                    next_mem[node] = NO_NODE;
                    if (elem_count == 0)
                    begin
                        prev_mem[node] = NO_NODE;
                        head_idx = {1'b0, node};
                    end
                    else
                    begin
                        prev_mem[node] = tail_idx;
                        if (tail_idx != NO_NODE)
                            next_mem[tail_idx[7:0]] = {1'b0, node};
                    end
                    tail_idx = {1'b0, node};
                    elem_count++;
                    in_queue[node] = 1'b1;
                    links_written[node] = 1'b1;
                end
            end
            llqm_pkg::CMD_POP:
            begin
                // A count with no head left behind is answered as an empty queue.
                if (elem_count == 0 || head_idx == NO_NODE)
                begin
                    resp.status = 1'b1;
                end
                else
                begin
                    top = head_idx[7:0];
                    resp.popped_node = top;
                    resp.pop_valid = 1'b1;
                    in_queue[top] = 1'b0;
                    if (elem_count == 1)
                    begin
                        head_idx = NO_NODE;
                        tail_idx = NO_NODE;
                    end
                    else
                    begin
                        head_idx = next_mem[top];
                        if (head_idx != NO_NODE)
                            prev_mem[head_idx[7:0]] = NO_NODE;
                    end
                    elem_count--;
                end
            end
            llqm_pkg::CMD_REMOVE:
            begin
                if (elem_count == 0)
                begin
                    resp.status = 1'b1;
                end
                else
                begin
                    nx = next_mem[node];
                    pv = prev_mem[node];
                    if ({1'b0, node} == head_idx)
                        head_idx = nx;
                    else if (pv != NO_NODE)
                        next_mem[pv[7:0]] = nx;
                    if ({1'b0, node} == tail_idx)
                        tail_idx = pv;
                    else if (nx != NO_NODE)
                        prev_mem[nx[7:0]] = pv;
                    elem_count--;
                    in_queue[node] = 1'b0;
                end
            end
            llqm_pkg::CMD_CLEAR:
            begin
                head_idx = NO_NODE;
                tail_idx = NO_NODE;
                elem_count = '0;
                foreach (in_queue[i])
                    in_queue[i] = 1'b0;
            end
        endcase
        resp.queue_count = elem_count;
        expected_resp_q.push_back(resp);
    endtask

    task automatic send_request(input llqm_pkg::cmd_t cmd, input logic [7:0] node);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= node;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_queue_command(cmd, node);
    endtask

    function automatic int pick_node(input int mode);
        int start;
        int idx;
        bit hit;
        start = $urandom_range(NODES - 1);
        for (int k = 0; k < NODES; k++)
        begin
            idx = (start + k) % NODES;
            case (mode)
                PICK_FREE:   hit = !in_queue[idx];
                PICK_MEMBER: hit = in_queue[idx];
                default:     hit = links_written[idx];
            endcase
            if (hit)
                return idx;
        end
        return -1;
    endfunction

    // Mostly well formed traffic; a few duplicate pushes and removes of non-members
    // stir up the links, which the shadow state follows exactly.
    task automatic send_random_command();
        int             roll;
        int             n;
        llqm_pkg::cmd_t cmd;
        logic [7:0]     node;
        roll = $urandom_range(99);
        node = 8'($urandom_range(255));
        n = -1;
        if (roll < 50)
        begin
            cmd = llqm_pkg::CMD_PUSH;
            if ($urandom_range(19) != 0)
                n = pick_node(PICK_FREE);
            if (n >= 0)
                node = 8'(n);
        end
        else if (roll < 75)
        begin
            cmd = llqm_pkg::CMD_POP;
        end
        else if (roll < 98)
        begin
            cmd = llqm_pkg::CMD_REMOVE;
            if (elem_count != 0 && $urandom_range(9) != 0)
                n = pick_node(PICK_MEMBER);
            // Only nodes whose links were written may be removed.
            if (n < 0)
                n = pick_node(PICK_WRITTEN);
            if (n < 0)
                cmd = llqm_pkg::CMD_POP;
            else
                node = 8'(n);
        end
        else
        begin
            cmd = llqm_pkg::CMD_CLEAR;
        end
        send_request(cmd, node);
    endtask

    task automatic test_basic_links();
        send_request(llqm_pkg::CMD_POP, 8'h3C);
        send_request(llqm_pkg::CMD_PUSH, 8'h00);
        send_request(llqm_pkg::CMD_PUSH, 8'hFF);
        send_request(llqm_pkg::CMD_PUSH, 8'h55);
        send_request(llqm_pkg::CMD_PUSH, 8'hAA);
        send_request(llqm_pkg::CMD_REMOVE, 8'h55);
        send_request(llqm_pkg::CMD_REMOVE, 8'h00);
        send_request(llqm_pkg::CMD_REMOVE, 8'hAA);
        send_request(llqm_pkg::CMD_POP, 8'hC3);
        send_request(llqm_pkg::CMD_POP, 8'hFF);
        send_request(llqm_pkg::CMD_REMOVE, 8'hFF);
        send_request(llqm_pkg::CMD_PUSH, 8'h01);
        send_request(llqm_pkg::CMD_PUSH, 8'h02);
        send_request(llqm_pkg::CMD_CLEAR, 8'hFF);
        send_request(llqm_pkg::CMD_POP, 8'h00);
        send_request(llqm_pkg::CMD_CLEAR, 8'h00);
    endtask

    // A duplicate push cuts the chain at the head, so the second pop finds a
    // nonzero count with no head.
    task automatic test_broken_links();
        send_request(llqm_pkg::CMD_PUSH, 8'h10);
        send_request(llqm_pkg::CMD_PUSH, 8'h20);
        send_request(llqm_pkg::CMD_PUSH, 8'h10);
        send_request(llqm_pkg::CMD_POP, 8'h00);
        send_request(llqm_pkg::CMD_POP, 8'h00);
        send_request(llqm_pkg::CMD_CLEAR, 8'h00);
    endtask

    task automatic test_full_queue();
        int order [$];
        for (int i = 0; i < NODES; i++)
            order.push_back(i);
        order.shuffle();
        foreach (order[i])
            send_request(llqm_pkg::CMD_PUSH, 8'(order[i]));
        send_request(llqm_pkg::CMD_PUSH, 8'(order[0]));
        send_request(llqm_pkg::CMD_POP, 8'h00);
        send_request(llqm_pkg::CMD_REMOVE, 8'(order[NODES - 1]));
        send_request(llqm_pkg::CMD_CLEAR, 8'h00);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_random_command();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // block has to hold its input off.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req_id++;
        repeat (24)
            send_random_command();
    endtask

    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        while (expected_resp_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_req_id != stall_ack_id)
        begin
            stall_ack_id = stall_req_id;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        queue_resp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_resp_q.size() == 0)
            begin
                report_mismatch("response with none pending, count",
                                int'(m_axis_tdata[8 +: CNT_W]), -1);
            end
            else
            begin
                want = expected_resp_q.pop_front();
                if (m_axis_tdata[7:0] !== want.popped_node)
                    report_mismatch("popped_node", int'(m_axis_tdata[7:0]),
                                    int'(want.popped_node));
                if (m_axis_tuser[0] !== want.pop_valid)
                    report_mismatch("pop_valid", int'(m_axis_tuser[0]), int'(want.pop_valid));
                if (m_axis_tdata[8 +: CNT_W] !== want.queue_count)
                    report_mismatch("queue_count", int'(m_axis_tdata[8 +: CNT_W]),
                                    int'(want.queue_count));
                if (m_axis_tuser[1] !== want.status)
                    report_mismatch("status", int'(m_axis_tuser[1]), int'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (next_mem[i])
        begin
            next_mem[i] = '0;
            prev_mem[i] = '0;
            in_queue[i] = 1'b0;
            links_written[i] = 1'b0;
        end
        head_idx = NO_NODE;
        tail_idx = NO_NODE;
        elem_count = '0;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_links();
        test_broken_links();
        test_full_queue();
        test_random_traffic(400, 35, 48);
        test_output_stall();
        test_random_traffic(400, 48, 35);
        test_random_traffic(400, 0, 0);
        drain_responses();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
